>>> rtl/core/pwfr_pkg.sv
// Shared types, constants and command structs of the pulse-width frame receiver.
`default_nettype none
package pwfr_pkg;

    // Frame store depth in bytes and the widths that follow from it.
    localparam int FRAME_BYTES  = 32;
    localparam int FRAME_ADDR_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int BIT_CNT_W    = $clog2(FRAME_BYTES * 8 + 1);
    localparam int BYTE_CNT_W   = BIT_CNT_W - 3;

    // Field widths.
    localparam int TIME_W  = 32;
    localparam int PULSE_W = 16;
    localparam int LIMIT_W = 7;
    localparam int CFG_A_W = 3;

    // Pulse window tolerances in microseconds.
    localparam int START_TOL = 20;
    localparam int BIT_TOL   = 15;
    localparam int ONE_MIN   = 55;
    localparam int END_TOL   = 20;

    // Configuration register indexes.
    localparam logic [CFG_A_W-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CFG_A_W-1:0] CFG_START  = 3'd1;
    localparam logic [CFG_A_W-1:0] CFG_ZERO   = 3'd2;
    localparam logic [CFG_A_W-1:0] CFG_ONE    = 3'd3;
    localparam logic [CFG_A_W-1:0] CFG_END    = 3'd4;

    // Configuration reset values.
    localparam logic [PULSE_W-1:0] START_RST = 16'd150;
    localparam logic [PULSE_W-1:0] ZERO_RST  = 16'd40;
    localparam logic [PULSE_W-1:0] ONE_RST   = 16'd70;
    localparam logic [PULSE_W-1:0] END_RST   = 16'd200;

    typedef enum logic [1:0] {
        RX_IDLE = 2'd0,
        RX_DATA = 2'd1,
        RX_END  = 2'd2
    } t_rx_state;

    typedef enum logic [2:0] {
        STS_EDGE     = 3'd0,
        STS_BYTE     = 3'd1,
        STS_EMPTY    = 3'd2,
        STS_REFUSED  = 3'd3,
        STS_NO_FRAME = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        C_IDLE    = 2'd0,
        C_EXEC    = 2'd1,
        C_RD_REQ  = 2'd2,
        C_RD_LOAD = 2'd3
    } t_ctrl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // latch the incoming beat
        logic exec;       // evaluate the latched item
        logic load_step;  // load the single result of the latched item
        logic rd_req;     // read the next frame byte from the store
        logic rd_load;    // load a frame byte result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic multi;      // latched item is a read that streams bytes
        logic rd_last;    // current frame byte is the final one
    } t_dp_stat;

endpackage
`default_nettype wire

>>> rtl/core/pwfr_ctrl.sv
// Sequencing state machine of the pulse-width frame receiver.
`default_nettype none
module pwfr_ctrl
    import pwfr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_s_valid,
    input  wire logic     i_m_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_s_ready,
    output logic          o_m_valid
);

    t_ctrl_state r_state, n_state;
    logic        r_m_valid, n_m_valid;
    logic        w_out_free;

    assign w_out_free = !r_m_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= C_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            C_IDLE: begin
                // No beat is taken while reset is held.
                o_s_ready = i_rst_n;
                if (i_s_valid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    n_state       = C_EXEC;
                end
            end
            C_EXEC: begin
                if (w_out_free) begin
                    o_cmd.exec = 1'b1;
                    if (i_stat.multi) begin
                        n_state = C_RD_REQ;
                    end else begin
                        o_cmd.load_step = 1'b1;
                        n_state         = C_IDLE;
                    end
                end
            end
            C_RD_REQ: begin
                o_cmd.rd_req = 1'b1;
                n_state      = C_RD_LOAD;
            end
            C_RD_LOAD: begin
                if (w_out_free) begin
                    o_cmd.rd_load = 1'b1;
                    n_state       = i_stat.rd_last ? C_IDLE : C_RD_REQ;
                end
            end
        endcase

        if (o_cmd.load_step || o_cmd.rd_load) begin
            n_m_valid = 1'b1;
        end else if (i_m_ready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    assign o_m_valid = r_m_valid;

endmodule
`default_nettype wire

>>> rtl/core/pwfr_dp.sv
// Datapath of the pulse-width frame receiver: registers, pulse decode and frame store.
`default_nettype none
module pwfr_dp
    import pwfr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_stat                o_stat,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_A_W-1:0] i_cfg_addr,
    input  wire logic [PULSE_W-1:0] i_cfg_wdata,
    input  wire logic               i_action,
    input  wire logic               i_level,
    input  wire logic [TIME_W-1:0]  i_time,
    input  wire logic [LIMIT_W-1:0] i_limit,
    output t_status                 o_status,
    output logic [7:0]              o_data_byte,
    output logic [LIMIT_W-1:0]      o_byte_count,
    output t_rx_state               o_recv_state,
    output logic                    o_frame_ready,
    output logic                    o_last
);

    // Configuration.
    logic               r_enable;
    logic [PULSE_W-1:0] r_start, r_zero, r_one, r_end;

    // Receiver state.
    logic [TIME_W-1:0]    r_last_rise, n_last_rise;
    t_rx_state            r_rx_state, n_rx_state;
    logic [BIT_CNT_W-1:0] r_bit_count, n_bit_count;
    logic                 r_frame_done, n_frame_done;
    logic [7:0]           r_cur_byte, n_cur_byte;

    // Latched item.
    logic               r_action, r_level;
    logic [TIME_W-1:0]  r_time, r_dur;
    logic [LIMIT_W-1:0] r_limit;

    // Read-out.
    logic [BYTE_CNT_W-1:0]   r_rd_n, n_rd_n;
    logic [FRAME_ADDR_W-1:0] r_rd_idx, n_rd_idx;
    logic [7:0]              r_rd_q;

    // Frame store.
    logic [7:0] r_mem [FRAME_BYTES];
    logic       w_mem_we;

    // Result register.
    t_status            r_out_status;
    logic [7:0]         r_out_data;
    logic [LIMIT_W-1:0] r_out_count;
    t_rx_state          r_out_state;
    logic               r_out_ready;
    logic               r_out_last;

    logic [PULSE_W-1:0]    w_start_lo, w_zero_lo, w_end_lo;
    logic [PULSE_W:0]      w_start_hi, w_one_hi;
    logic                  w_in_start, w_in_bit, w_in_end, w_bit_val, w_full;
    logic [2:0]            w_bp;
    logic [7:0]            w_assembled;
    logic [BYTE_CNT_W-1:0] w_bytes, w_rd_n_calc;
    logic                  w_clear;
    t_status               w_step_status;

    // Pulse windows; lower bounds saturate at zero.
    assign w_start_lo = (r_start >= PULSE_W'(START_TOL)) ? r_start - PULSE_W'(START_TOL) : '0;
    assign w_start_hi = {1'b0, r_start} + (PULSE_W + 1)'(START_TOL);
    assign w_zero_lo  = (r_zero >= PULSE_W'(BIT_TOL)) ? r_zero - PULSE_W'(BIT_TOL) : '0;
    assign w_one_hi   = {1'b0, r_one} + (PULSE_W + 1)'(BIT_TOL);
    assign w_end_lo   = (r_end >= PULSE_W'(END_TOL)) ? r_end - PULSE_W'(END_TOL) : '0;

    assign w_in_start = (r_dur >= TIME_W'(w_start_lo)) && (r_dur <= TIME_W'(w_start_hi));
    assign w_in_bit   = (r_dur >= TIME_W'(w_zero_lo)) && (r_dur <= TIME_W'(w_one_hi));
    assign w_in_end   = r_dur >= TIME_W'(w_end_lo);
    assign w_bit_val  = r_dur >= TIME_W'(ONE_MIN);

    assign w_full      = r_bit_count >= BIT_CNT_W'(FRAME_BYTES * 8);
    assign w_bp        = r_bit_count[2:0];
    assign w_assembled = ((w_bp == 3'd0) ? 8'h00 : r_cur_byte) | (8'(w_bit_val) << w_bp);
    assign w_bytes     = r_bit_count[BIT_CNT_W-1:3];
    assign w_rd_n_calc = (LIMIT_W'(w_bytes) <= r_limit) ? w_bytes : BYTE_CNT_W'(r_limit);

    assign o_stat.multi   = r_action && r_enable && (r_limit != '0) && r_frame_done
                            && (w_rd_n_calc != '0);
    assign o_stat.rd_last = (BYTE_CNT_W'(r_rd_idx) + BYTE_CNT_W'(1)) == r_rd_n;

    always_comb begin
        n_last_rise   = r_last_rise;
        n_rx_state    = r_rx_state;
        n_bit_count   = r_bit_count;
        n_frame_done  = r_frame_done;
        n_cur_byte    = r_cur_byte;
        n_rd_n        = r_rd_n;
        n_rd_idx      = r_rd_idx;
        w_mem_we      = 1'b0;
        w_clear       = 1'b0;
        w_step_status = STS_EDGE;

        // Turning the receiver on drops any partial frame.
        if (i_cfg_we && (i_cfg_addr == CFG_ENABLE) && i_cfg_wdata[0] && !r_enable) begin
            w_clear = 1'b1;
        end

        if (i_cmd.exec) begin
            if (!r_action) begin
                if (r_enable) begin
                    if (r_level) begin
                        n_last_rise = r_time;
                    end else begin
                        case (r_rx_state)
                            RX_IDLE: begin
                                if (w_in_start) begin
                                    n_rx_state  = RX_DATA;
                                    n_bit_count = '0;
                                end
                            end
                            RX_DATA: begin
                                if (w_in_bit) begin
                                    // Bits past a full store are dropped.
                                    if (!w_full) begin
                                        n_cur_byte  = w_assembled;
                                        n_bit_count = r_bit_count + BIT_CNT_W'(1);
                                        w_mem_we    = (w_bp == 3'd7);
                                    end
                                end else if (w_in_end) begin
                                    n_rx_state   = RX_END;
                                    n_frame_done = 1'b1;
                                end else begin
                                    w_clear = 1'b1;
                                end
                            end
                            default: begin
                                w_clear = 1'b1;
                            end
                        endcase
                    end
                end
            end else if (!r_enable || (r_limit == '0)) begin
                w_step_status = STS_REFUSED;
            end else if (!r_frame_done) begin
                w_step_status = STS_NO_FRAME;
            end else begin
                w_clear       = 1'b1;
                w_step_status = STS_EMPTY;
                n_rd_n        = w_rd_n_calc;
                n_rd_idx      = '0;
            end
        end

        if (i_cmd.rd_load) begin
            n_rd_idx = r_rd_idx + FRAME_ADDR_W'(1);
        end

        if (w_clear) begin
            n_rx_state   = RX_IDLE;
            n_bit_count  = '0;
            n_frame_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_start      <= START_RST;
            r_zero       <= ZERO_RST;
            r_one        <= ONE_RST;
            r_end        <= END_RST;
            r_last_rise  <= '0;
            r_rx_state   <= RX_IDLE;
            r_bit_count  <= '0;
            r_frame_done <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_ENABLE: r_enable <= i_cfg_wdata[0];
                    CFG_START:  r_start  <= i_cfg_wdata;
                    CFG_ZERO:   r_zero   <= i_cfg_wdata;
                    CFG_ONE:    r_one    <= i_cfg_wdata;
                    CFG_END:    r_end    <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_last_rise  <= n_last_rise;
            r_rx_state   <= n_rx_state;
            r_bit_count  <= n_bit_count;
            r_frame_done <= n_frame_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_byte <= n_cur_byte;
        r_rd_n     <= n_rd_n;
        r_rd_idx   <= n_rd_idx;
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_level  <= i_level;
            r_time   <= i_time;
            r_limit  <= i_limit;
            r_dur    <= i_time - r_last_rise;
        end
        if (i_cmd.load_step) begin
            r_out_status <= w_step_status;
            r_out_data   <= 8'h00;
            r_out_count  <= '0;
            r_out_state  <= n_rx_state;
            r_out_ready  <= n_frame_done;
            r_out_last   <= 1'b1;
        end else if (i_cmd.rd_load) begin
            r_out_status <= STS_BYTE;
            r_out_data   <= r_rd_q;
            r_out_count  <= LIMIT_W'(r_rd_n);
            r_out_state  <= RX_IDLE;
            r_out_ready  <= 1'b0;
            r_out_last   <= o_stat.rd_last;
        end
    end

    // Completed bytes are written once; read-out is one registered read per byte.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_bit_count[FRAME_ADDR_W+2:3]] <= w_assembled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_req) begin
            r_rd_q <= r_mem[r_rd_idx];
        end
    end

    assign o_status      = r_out_status;
    assign o_data_byte   = r_out_data;
    assign o_byte_count  = r_out_count;
    assign o_recv_state  = r_out_state;
    assign o_frame_ready = r_out_ready;
    assign o_last        = r_out_last;

endmodule
`default_nettype wire

>>> rtl/core/pulse_width_frame_receiver.sv
// Top level of the pulse-width frame receiver: stream ports, controller and datapath.
`default_nettype none
// The receiver decodes pulse-width coded frames from timestamped line edges. Each
// input beat is either a line edge (tuser low) or a read request (tuser high). A
// rising edge records its time; a falling edge measures the high time as a 32-bit
// wrapping difference and steps the receiver through idle, data and ended states.
// Data bits are packed LSB-first into bytes held in a 32-byte frame store. An edge
// beat is captured, then evaluated once the result register is free, and returns
// one result beat. A read of a complete frame returns one beat per stored byte up
// to the read limit, tlast on the final byte, each fetched by a registered read of
// the frame store; refused, empty and no-frame reads return one beat. The result
// register decouples the sides: a new beat is taken while the last result still
// waits on the master side. Configuration writes are registered and must only be
// issued while the block is idle; enabling the receiver clears any partial frame.
// There is no clearing pass after reset.
module pulse_width_frame_receiver
    import pwfr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Configuration write port.
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_A_W-1:0] i_cfg_addr,
    input  wire logic [PULSE_W-1:0] i_cfg_wdata,
    // Input stream.
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [39:0]        s_axis_tdata,  // edge_level[0], time_us[32:1], read_limit[39:33]
    input  wire logic               s_axis_tuser,  // action[0]
    // Result stream.
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [23:0]             m_axis_tdata,  // data_byte[7:0], byte_count[14:8],
                                                   // recv_state[16:15], frame_ready[17], zeros
    output logic [2:0]              m_axis_tuser,  // status[2:0]
    output logic                    m_axis_tlast
);

    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;
    t_status            w_status;
    logic [7:0]         w_data_byte;
    logic [LIMIT_W-1:0] w_byte_count;
    t_rx_state          w_recv_state;
    logic               w_frame_ready;

    pwfr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid)
    );

    pwfr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_action      (s_axis_tuser),
        .i_level       (s_axis_tdata[0]),
        .i_time        (s_axis_tdata[32:1]),
        .i_limit       (s_axis_tdata[39:33]),
        .o_status      (w_status),
        .o_data_byte   (w_data_byte),
        .o_byte_count  (w_byte_count),
        .o_recv_state  (w_recv_state),
        .o_frame_ready (w_frame_ready),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {6'b0, w_frame_ready, 2'(w_recv_state), w_byte_count, w_data_byte};
    assign m_axis_tuser = 3'(w_status);

endmodule
`default_nettype wire
